>>> src/adtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtd_pkg
// Shared types, constants and calendar functions for the date adder.
// ----------------------------------------------------------------------------
package adtd_pkg;

    localparam int unsigned MonthsPerYear = 12;
    localparam int unsigned YearWidth     = 14;
    localparam int unsigned ModWidth      = 9;   // holds year mod 400
    localparam int unsigned RemWidth      = 16;  // day count during the walk
    localparam int unsigned ModSteps      = 6;
    localparam int unsigned StepWidth     = 3;

    // controller to datapath
    typedef struct packed {
        logic                 load;      // capture the input transfer
        logic                 mod_step;  // one conditional subtract of year mod 400
        logic [StepWidth-1:0] step_idx;
        logic                 prefix;    // form day-of-year plus day count
        logic                 walk_step; // retire one month
        logic                 out_load;  // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fits;                      // remainder fits in the current month
    } t_sts;

    // subtrahends for the year mod 400 reduction, largest first
    function automatic logic [YearWidth-1:0] mod_sub(input logic [StepWidth-1:0] idx);
        logic [YearWidth-1:0] v;
        case (idx)
            3'd0:    v = 14'd12800;
            3'd1:    v = 14'd6400;
            3'd2:    v = 14'd3200;
            3'd3:    v = 14'd1600;
            3'd4:    v = 14'd800;
            3'd5:    v = 14'd400;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // days before month m in a common year, m = 0..12
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        case (m)
            4'd2:                      v = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
            default:                   v = 5'd31;
        endcase
        return v;
    endfunction

    // leap test from year mod 400
    function automatic logic is_leap(input logic [ModWidth-1:0] r);
        return (r == 9'd0) ||
               ((r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
    endfunction

endpackage

>>> src/adtd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtd_dp
// Datapath: year mod 400 reduction, day-of-year prefix and month walk.
// ----------------------------------------------------------------------------
module adtd_dp
    import adtd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [4:0]           i_start_day,
    input  logic [3:0]           i_start_month,
    input  logic [YearWidth-1:0] i_start_year,
    input  logic [14:0]          i_days_to_add,
    output t_sts                 o_sts,
    output logic [4:0]           o_result_day,
    output logic [3:0]           o_result_month,
    output logic [YearWidth-1:0] o_result_year
);

    logic [4:0]           r_day;
    logic [3:0]           r_mon;
    logic [YearWidth-1:0] r_year;
    logic [YearWidth-1:0] r_ymod;
    logic [14:0]          r_add;
    logic [RemWidth-1:0]  r_rem;
    logic [3:0]           r_m;
    logic [4:0]           r_out_day;
    logic [3:0]           r_out_month;
    logic [YearWidth-1:0] r_out_year;

    logic                 leap;
    logic [4:0]           cur_len;
    logic [YearWidth-1:0] sub;
    logic [RemWidth-1:0]  prefix_sum;

    assign leap    = is_leap(r_ymod[ModWidth-1:0]);
    assign cur_len = month_len(r_m, leap);
    assign sub     = mod_sub(i_cmd.step_idx);
    assign prefix_sum = RemWidth'(r_day) + RemWidth'(cum_days(r_mon))
                      + RemWidth'(leap && (r_mon >= 4'd3)) + RemWidth'(r_add);

    assign o_sts.fits = (r_rem <= RemWidth'(cur_len));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day  <= i_start_day;
            // months above twelve saturate
            r_mon  <= (i_start_month > 4'(MonthsPerYear)) ? 4'(MonthsPerYear) : i_start_month;
            r_year <= i_start_year;
            r_ymod <= i_start_year;
            r_add  <= i_days_to_add;
        end
        if (i_cmd.mod_step && (r_ymod >= sub)) begin
            r_ymod <= r_ymod - sub;
        end
        if (i_cmd.prefix) begin
            r_rem <= prefix_sum;
            r_m   <= 4'd1;
        end
        if (i_cmd.walk_step) begin
            r_rem <= r_rem - RemWidth'(cur_len);
            if (r_m == 4'(MonthsPerYear)) begin
                r_m    <= 4'd1;
                r_year <= r_year + 1'b1;
                r_ymod <= (r_ymod == 14'd399) ? '0 : r_ymod + 1'b1;
            end else begin
                r_m <= r_m + 1'b1;
            end
        end
        if (!i_rst_n) begin
            r_out_day   <= '0;
            r_out_month <= '0;
            r_out_year  <= '0;
        end else if (i_cmd.out_load) begin
            r_out_day   <= r_rem[4:0];
            r_out_month <= r_m;
            r_out_year  <= r_year;
        end
    end

    assign o_result_day   = r_out_day;
    assign o_result_month = r_out_month;
    assign o_result_year  = r_out_year;

endmodule

>>> src/adtd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adtd_ctrl
// Controller: sequences reduction, prefix and walk; owns the handshakes.
// ----------------------------------------------------------------------------
module adtd_ctrl
    import adtd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_PRE  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [StepWidth-1:0] r_step, n_step;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step_idx = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_MOD;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == StepWidth'(ModSteps - 1)) begin
                    n_state = ST_PRE;
                end
            end
            ST_PRE: begin
                o_cmd.prefix = 1'b1;
                n_state      = ST_WALK;
            end
            ST_WALK: begin
                if (!i_sts.fits) begin
                    o_cmd.walk_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/add_days_to_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// add_days_to_date_unit
// Advances a Gregorian date by a day count, one month per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one start date and day count per transfer; m_axis returns
//   the resulting date, one transfer per input.
//   Steps: accept the item, reduce the year mod 400 by conditional subtracts,
//   form the day-of-year sum, walk the months, then move the result into the
//   output register. Walk length is the number of whole months between
//   January of the start year and the result, up to about 1090 for the
//   largest day count. The month walk loop, one subtract and compare per
//   cycle, sets the rate.
//   Items are processed one at a time; s_axis_tready is high while the unit
//   is waiting for work, also while a result sits in the output register.
//   If the receiver stalls with a result still held, a finished walk waits
//   until the output register frees up, then the unit takes the next item.
//   Synchronous active-low reset empties the output register and returns the
//   controller to idle.
// ----------------------------------------------------------------------------
module add_days_to_date_unit
    import adtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[37:23]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_day[4:0], result_month[8:5], result_year[22:9]
    output logic [23:0] m_axis_tdata
);

    t_cmd                 cmd;
    t_sts                 sts;
    logic [4:0]           result_day;
    logic [3:0]           result_month;
    logic [YearWidth-1:0] result_year;

    adtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    adtd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_start_day    (s_axis_tdata[4:0]),
        .i_start_month  (s_axis_tdata[8:5]),
        .i_start_year   (s_axis_tdata[22:9]),
        .i_days_to_add  (s_axis_tdata[37:23]),
        .o_sts          (sts),
        .o_result_day   (result_day),
        .o_result_month (result_month),
        .o_result_year  (result_year)
    );

    assign m_axis_tdata = {1'b0, result_year, result_month, result_day};

endmodule
